/* hw/rtl/sha256_byte_stream_hash_defines.svh */
// Assertion macros used by the checker file
`ifndef SHA256_BYTE_STREAM_HASH_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASH_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked on the next edge
`define SHA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/sha_pkg.sv */
`default_nettype none
package sha_pkg;

   typedef enum logic [1:0] {
      CMD_ABSORB  = 2'd0,
      CMD_DIGEST  = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Control from sequencer to round unit
   typedef struct packed {
      logic       load;   // load vars from hash, window from block
      logic       step;   // run one round
      logic [5:0] round;
   } rnd_ctl_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] MSG_END_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS      = 6'd56;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha_stream_if.sv */
`default_nettype none
interface sha_stream_if #(
   parameter int Width = 8
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sha256_byte_stream_hash.sv */
// SHA-256 over a byte stream, one round per cycle on a shared round unit.
// Absorb: the byte is buffered; when it completes a block, the block is compressed
// Digest: the padded block is compressed (then a second padded block when 56 or more
//   bytes are held), then eight result transactions, one per cycle with rsp.ready.
// Throughput: one transaction at a time; req.ready stays low until it is done.
// Restart reloads the initial hash and clears the counts. Reset is synchronous: initial hash loaded, counts cleared.
`default_nettype none
module sha256_byte_stream_hash (
   input  wire logic  clock,
   input  wire logic  reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
   } state_type;

   state_type        state_ff;
   logic [255:0]     chain_ff;      // running hash
   logic [255:0]     work_ff;       // hash being compressed
   logic [511:0]     buf_ff;        // message bytes, byte 0 in the top lane
   logic [511:0]     pad_ff;        // block fed to the round unit
   logic [5:0]       fill_ff;
   logic [60:0]      count_ff;
   logic [5:0]       round_ff;
   logic             digest_ff;     // compressing for a digest
   logic             second_ff;     // digest needs a second padded block
   logic [2:0]       widx_ff;
   sha_pkg::req_type rq;
   sha_pkg::rnd_ctl_type ctl;
   logic [255:0]     folded;
   logic [511:0]     pad_a, pad_b;
   logic [63:0]      bits;

   assign rq = req.payload;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.payload = sha_pkg::rsp_type'{digest_word: work_ff[255-32*widx_ff -: 32],
                                           word_index: widx_ff,
                                           last_word: (widx_ff == 3'd7)};

   assign ctl.load  = (state_ff == ST_LOAD);
   assign ctl.step  = (state_ff == ST_ROUND);
   assign ctl.round = round_ff;

   sha_round u_round (
      .clock    (clock),
      .ctl      (ctl),
      .block    (pad_ff),
      .hash_in  (work_ff),
      .hash_out (folded)
   );

   // Padded blocks built from the buffer
   always_comb begin
      bits = {count_ff, 3'b000};
      for (int i = 0; i < 64; i++) begin
         if (i < fill_ff) pad_a[511-8*i -: 8] = buf_ff[511-8*i -: 8];
         else if (i == fill_ff) pad_a[511-8*i -: 8] = sha_pkg::MSG_END_BYTE;
         else pad_a[511-8*i -: 8] = 8'h00;
         pad_b[511-8*i -: 8] = 8'h00;
      end
      if (fill_ff < sha_pkg::LEN_POS) pad_a[63:0] = bits;
      pad_b[63:0] = bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         round_ff <= '0;
         widx_ff  <= '0;
         digest_ff <= 1'b0;
         second_ff <= 1'b0;
         for (int j = 0; j < 8; j++) chain_ff[255-32*j -: 32] <= sha_pkg::INIT_HASH[j];
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  case (rq.command)
                     sha_pkg::CMD_ABSORB: begin
                        buf_ff[511-8*fill_ff -: 8] <= rq.data_byte;
                        fill_ff  <= fill_ff + 6'd1;
                        count_ff <= count_ff + 61'd1;
                        if (fill_ff == 6'd63) begin
                           pad_ff    <= {buf_ff[511:8], rq.data_byte};
                           work_ff   <= chain_ff;
                           digest_ff <= 1'b0;
                           state_ff  <= ST_LOAD;
                        end
                     end
                     sha_pkg::CMD_DIGEST: begin
                        pad_ff    <= pad_a;
                        work_ff   <= chain_ff;
                        digest_ff <= 1'b1;
                        second_ff <= (fill_ff >= sha_pkg::LEN_POS);
                        state_ff  <= ST_LOAD;
                     end
                     sha_pkg::CMD_RESTART: begin
                        fill_ff  <= '0;
                        count_ff <= '0;
                        for (int j = 0; j < 8; j++)
                           chain_ff[255-32*j -: 32] <= sha_pkg::INIT_HASH[j];
                     end
                     default: ;
                  endcase
               end
            end
            ST_LOAD: begin
               round_ff <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               work_ff <= folded;
               if (!digest_ff) begin
                  chain_ff <= folded;
                  state_ff <= ST_IDLE;
               end else if (second_ff) begin
                  second_ff <= 1'b0;
                  pad_ff    <= pad_b;
                  state_ff  <= ST_LOAD;
               end else begin
                  widx_ff  <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp.ready) begin
                  widx_ff <= widx_ff + 3'd1;
                  if (widx_ff == 3'd7) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/sha_round.sv */
`default_nettype none
// One SHA-256 round per cycle while ctl.step is high, over a 16-word rolling schedule window
module sha_round (
   input  wire logic                  clock,
   input  wire sha_pkg::rnd_ctl_type  ctl,
   input  wire logic [511:0]          block,
   input  wire logic [255:0]          hash_in,
   output logic [255:0]               hash_out
);

   logic [31:0] win_ff [16];
   logic [31:0] var_ff [8];
   logic [31:0] wi, s0, s1, t1, t2, a, e, w2, w15;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Schedule word and round function
   always_comb begin
      w2  = win_ff[14];
      w15 = win_ff[1];
      s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
      s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
      wi  = (ctl.round < 6'd16) ? win_ff[0] : (s1 + win_ff[9] + s0 + win_ff[0]);
      a   = var_ff[0];
      e   = var_ff[4];
      t1  = var_ff[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) +
            ((e & var_ff[5]) ^ (~e & var_ff[6])) + sha_pkg::round_k(ctl.round) + wi;
      t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) +
            ((a & var_ff[1]) ^ (a & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
      for (int j = 0; j < 8; j++) begin
         hash_out[255-32*j -: 32] = hash_in[255-32*j -: 32] + var_ff[j];
      end
   end

   // Window shifts one word per round, vars rotate
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < 16; i++) win_ff[i] <= block[511-32*i -: 32];
         for (int j = 0; j < 8; j++) var_ff[j] <= hash_in[255-32*j -: 32];
      end else if (ctl.step) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= wi;
         var_ff[0] <= t1 + t2;
         var_ff[1] <= var_ff[0];
         var_ff[2] <= var_ff[1];
         var_ff[3] <= var_ff[2];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[5] <= var_ff[4];
         var_ff[6] <= var_ff[5];
         var_ff[7] <= var_ff[6];
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/sha_checker.sv */
`default_nettype none
`include "sha256_byte_stream_hash_defines.svh"
module sha_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire logic [35:0]  rsp_payload
);
   // Never take a request while results are pending
   `SHA_ASSERT_IMP(a_no_overlap, rsp_valid, !req_ready)
   // Word index advances after each delivered word but the last
   `SHA_ASSERT_NXT(a_index_step, rsp_valid && rsp_ready && !rsp_payload[0],
      rsp_valid && (rsp_payload[3:1] == $past(rsp_payload[3:1]) + 3'd1))
   // Last word flag matches index seven
   `SHA_ASSERT_IMP(a_last_flag, rsp_valid, rsp_payload[0] == (rsp_payload[3:1] == 3'd7))
   // Any accepted request, a digest included, starts computing or idling, not emitting
   `SHA_ASSERT_NXT(a_req_stall, req_valid && req_ready, !rsp_valid)
endmodule

bind sha256_byte_stream_hash sha_checker u_sha_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
`default_nettype wire
